// ===== rtl/core/ptrf_pkg.sv =====
// Shared types and constants for the pipe table ring FIFO.
package ptrf_pkg;

    localparam int DESC_BASE = 2;
    localparam int Q_DEPTH   = 2;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_DESTROY = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_FD  = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_NO_SLOT = 3'd4
    } t_status;

    // work the back end has to do for one request
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_CREATE = 2'd1,
        OP_WRITE  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] fd;
        logic [7:0]  data_in;
        logic        end_of_transfer;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [2:0]  slot;
        logic [15:0] read_end_fd;
        logic [15:0] write_end_fd;
        logic [7:0]  data_out;
        logic        transfer_end;
    } t_res;

    typedef struct packed {
        t_op  op;
        logic [7:0] data;
        t_res res;
    } t_job;

endpackage

// ===== rtl/core/ptrf_front.sv =====
// Front end: request register, descriptor matching and slot table.
module ptrf_front import ptrf_pkg::*; #(
    parameter int SLOTS = 8,
    parameter int SW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  t_req          i_req,
    output logic          busy,
    input  logic          i_q_full,
    output logic          o_push,
    output logic [SW-1:0] o_push_slot,
    output t_job          o_push_job
);

    logic              r_valid;
    t_req              r_req;
    logic [SLOTS-1:0]  r_used;
    logic [15:0]       r_rend [SLOTS];
    logic [15:0]       r_wend [SLOTS];
    logic [15:0]       r_next_desc;

    logic              in_range;
    logic              wr_hit, rd_hit, free_hit;
    logic [SW-1:0]     wr_idx, rd_idx, free_idx;
    logic              do_create, do_destroy;
    logic [15:0]       wfd;

    assign busy   = r_valid & i_q_full;
    assign o_push = r_valid & ~i_q_full;
    assign wfd    = r_next_desc + 16'd1;

    assign in_range = (r_req.fd >= 16'(DESC_BASE)) && (r_req.fd < r_next_desc);

    // lowest index wins: scan from the top down
    always_comb begin
        wr_hit   = 1'b0;
        rd_hit   = 1'b0;
        free_hit = 1'b0;
        wr_idx   = '0;
        rd_idx   = '0;
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_used[s] && r_wend[s] == r_req.fd) begin
                wr_hit = 1'b1;
                wr_idx = SW'(s);
            end
            if (r_used[s] && r_rend[s] == r_req.fd) begin
                rd_hit = 1'b1;
                rd_idx = SW'(s);
            end
            if (!r_used[s]) begin
                free_hit = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    always_comb begin
        o_push_slot                 = '0;
        o_push_job.op               = OP_NONE;
        o_push_job.data             = r_req.data_in;
        o_push_job.res.status       = ST_OK;
        o_push_job.res.slot         = '0;
        o_push_job.res.read_end_fd  = '0;
        o_push_job.res.write_end_fd = '0;
        o_push_job.res.data_out     = '0;
        o_push_job.res.transfer_end = r_req.end_of_transfer;
        do_create                   = 1'b0;
        do_destroy                  = 1'b0;
        unique case (t_cmd'(r_req.command))
            CMD_CREATE: begin
                if (free_hit) begin
                    do_create                   = 1'b1;
                    o_push_job.op               = OP_CREATE;
                    o_push_slot                 = free_idx;
                    o_push_job.res.slot         = 3'(free_idx);
                    o_push_job.res.read_end_fd  = r_next_desc;
                    o_push_job.res.write_end_fd = wfd;
                end else begin
                    o_push_job.res.status = ST_NO_SLOT;
                end
            end
            CMD_WRITE: begin
                if (in_range && wr_hit) begin
                    o_push_job.op = OP_WRITE;
                    o_push_slot   = wr_idx;
                end else begin
                    o_push_job.res.status = ST_BAD_FD;
                end
            end
            CMD_READ: begin
                if (in_range && rd_hit) begin
                    o_push_job.op = OP_READ;
                    o_push_slot   = rd_idx;
                end else begin
                    o_push_job.res.status = ST_BAD_FD;
                end
            end
            CMD_DESTROY: begin
                if (wr_hit) begin
                    do_destroy = 1'b1;
                end else begin
                    o_push_job.res.status = ST_BAD_FD;
                end
            end
            default: begin
                o_push_job.res.status = ST_BAD_FD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_used      <= '0;
            r_next_desc <= 16'(DESC_BASE);
        end else begin
            if (start && !busy) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
            if (o_push && do_create) begin
                r_used[free_idx] <= 1'b1;
                r_next_desc      <= r_next_desc + 16'd2;
            end
            if (o_push && do_destroy) begin
                r_used[wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        if (o_push && do_create) begin
            r_rend[free_idx] <= r_next_desc;
            r_wend[free_idx] <= wfd;
        end
    end

endmodule

// ===== rtl/core/ptrf_queue.sv =====
// Short job queue between front and back end.
module ptrf_queue import ptrf_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full
);

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [QAW-1:0]    r_wr, r_rd;
    logic [QCW-1:0]    r_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCW'(Q_DEPTH));
    assign o_data  = r_mem[r_rd];
    assign pop     = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QAW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/core/ptrf_back.sv =====
// Back end: per-slot ring pointers, ring memory and result register.
module ptrf_back import ptrf_pkg::*; #(
    parameter int SLOTS      = 8,
    parameter int RING_DEPTH = 256,
    parameter int SW         = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [SW-1:0] i_slot,
    input  t_job          i_job,
    output logic          o_valid,
    output t_res          o_res
);

    localparam int PW        = $clog2(RING_DEPTH);
    localparam int CW        = $clog2(RING_DEPTH + 1);
    localparam int MEM_DEPTH = SLOTS * (2 ** PW);
    localparam int AW        = $clog2(MEM_DEPTH);

    logic [PW-1:0] r_head [SLOTS];
    logic [PW-1:0] r_tail [SLOTS];
    logic [CW-1:0] r_fill [SLOTS];
    logic [7:0]    r_ring [MEM_DEPTH];
    logic [7:0]    r_mem_q;

    logic          r_y_valid;
    logic          r_y_rd_ok;
    t_res          r_y_res;

    logic [PW-1:0] head, tail, head_inc, tail_inc;
    logic [CW-1:0] fill;
    logic          wr_en, rd_en, clr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_res          n_res;

    assign head     = r_head[i_slot];
    assign tail     = r_tail[i_slot];
    assign fill     = r_fill[i_slot];
    assign head_inc = (head == PW'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
    assign tail_inc = (tail == PW'(RING_DEPTH - 1)) ? '0 : tail + 1'b1;
    assign wr_addr  = AW'({i_slot, tail});
    assign rd_addr  = AW'({i_slot, head});

    always_comb begin
        n_res  = i_job.res;
        wr_en  = 1'b0;
        rd_en  = 1'b0;
        clr_en = 1'b0;
        unique case (i_job.op)
            OP_CREATE: begin
                clr_en = i_valid;
            end
            OP_WRITE: begin
                if (fill == CW'(RING_DEPTH)) begin
                    n_res.status = ST_FULL;
                end else begin
                    wr_en = i_valid;
                end
            end
            OP_READ: begin
                if (fill == '0) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    rd_en = i_valid;
                end
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (clr_en) begin
            r_head[i_slot] <= '0;
            r_tail[i_slot] <= '0;
            r_fill[i_slot] <= '0;
        end
        if (wr_en) begin
            r_tail[i_slot] <= tail_inc;
            r_fill[i_slot] <= fill + 1'b1;
        end
        if (rd_en) begin
            r_head[i_slot] <= head_inc;
            r_fill[i_slot] <= fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= i_job.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mem_q <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_valid <= 1'b0;
        end else begin
            r_y_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y_res   <= n_res;
        r_y_rd_ok <= rd_en;
    end

    assign o_valid = r_y_valid;

    always_comb begin
        o_res = r_y_res;
        if (r_y_rd_ok) begin
            o_res.data_out = r_mem_q;
        end
    end

    a_strobe_follows_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_y_valid |-> $past(i_valid))
        else $error("result strobe without a job");

    a_read_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_y_valid && r_y_rd_ok) |-> (r_y_res.status == ST_OK))
        else $error("read data returned with failing status");

endmodule

// ===== rtl/core/pipe_table_ring_fifo_core.sv =====
// Top level of the pipe table ring FIFO: front end, job queue and back end.
//
// A table of SLOTS byte pipes, each a ring FIFO of RING_DEPTH bytes held in
// one shared ring memory. A request is taken on a clock edge with start high
// and busy low; every request gives exactly one result, shown for a single
// cycle with o_valid high. The receiver cannot hold results off, so o_res
// must be captured in that cycle. Timing: the front end registers the
// request, matches its descriptor against the slot table in the next cycle
// and queues a job; the back end then does the single ring memory access and
// registers the result. The back end retires one job every cycle, so
// requests may be issued every cycle; busy rises only if the job queue
// fills. No clearing pass is needed after reset: pipes are reset when
// created.
module pipe_table_ring_fifo_core import ptrf_pkg::*; #(
    parameter int SLOTS      = 8,
    parameter int RING_DEPTH = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    // slot index width; a single-slot table still carries one bit
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int JOB_W  = SW + $bits(t_job);

    logic             q_full, q_valid, push;
    logic [SW-1:0]    push_slot, job_slot;
    t_job             push_job, job;
    logic [JOB_W-1:0] q_out;

    // front: accepts requests, owns slot table and descriptor counter
    ptrf_front #(
        .SLOTS (SLOTS),
        .SW    (SW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_slot (push_slot),
        .o_push_job  (push_job)
    );

    // queue keeps jobs in request order
    ptrf_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_slot, push_job}),
        .i_pop       (q_valid),
        .o_valid     (q_valid),
        .o_data      (q_out),
        .o_full      (q_full)
    );

    assign job_slot = q_out[JOB_W-1 -: SW];
    assign job      = t_job'(q_out[$bits(t_job)-1:0]);

    // back: ring pointers, byte storage, full/empty status, result strobe
    ptrf_back #(
        .SLOTS      (SLOTS),
        .RING_DEPTH (RING_DEPTH),
        .SW         (SW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_slot  (job_slot),
        .i_job   (job),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

// ===== tb/sv/pipe_table_checker.sv =====
// Request/result monitor and scoreboard for the pipe table ring FIFO.
`timescale 1ns / 100ps

module pipe_table_checker import ptrf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_valid,
    input  t_res i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int SLOTS       = 8;
    localparam int RING_DEPTH  = 256;
    localparam int MAX_REPORTS = 10;

    // own copy of the pipe table
    logic        used     [SLOTS];
    logic [15:0] rd_end   [SLOTS];
    logic [15:0] wr_end   [SLOTS];
    logic [7:0]  head     [SLOTS];
    logic [7:0]  tail     [SLOTS];
    logic [8:0]  fill     [SLOTS];
    logic [7:0]  ring     [SLOTS*RING_DEPTH];
    logic [15:0] next_fd;

    t_res pending_results[$];
    int   fails = 0;

    // lowest used slot whose chosen end equals fd, -1 if none
    function automatic int match_slot(logic [15:0] fd, bit by_wr);
        for (int s = 0; s < SLOTS; s++) begin
            if (used[s] && (by_wr ? wr_end[s] : rd_end[s]) == fd) return s;
        end
        return -1;
    endfunction

    function automatic bit fd_issued(logic [15:0] fd);
        return fd >= 16'(DESC_BASE) && fd < next_fd;
    endfunction

    // result of one request; updates the table copy
    function automatic t_res next_pipe_result(t_req req);
        t_res r;
        int   s;
        r              = '0;
        r.status       = ST_OK;
        r.transfer_end = req.end_of_transfer;
        case (t_cmd'(req.command))
            CMD_CREATE: begin
                s = -1;
                for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) s = i;
                if (s < 0) begin
                    r.status = ST_NO_SLOT;
                end else begin
                    used[s]        = 1'b1;
                    rd_end[s]      = next_fd;
                    wr_end[s]      = next_fd + 16'd1;
                    head[s]        = '0;
                    tail[s]        = '0;
                    fill[s]        = '0;
                    r.slot         = 3'(s);
                    r.read_end_fd  = next_fd;
                    r.write_end_fd = next_fd + 16'd1;
                    next_fd        = next_fd + 16'd2;
                end
            end
            CMD_WRITE: begin
                s = fd_issued(req.fd) ? match_slot(req.fd, 1'b1) : -1;
                if (s < 0) begin
                    r.status = ST_BAD_FD;
                end else if (fill[s] >= RING_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring[s*RING_DEPTH + int'(tail[s])] = req.data_in;
                    tail[s] = 8'((int'(tail[s]) + 1) % RING_DEPTH);
                    fill[s] = fill[s] + 9'd1;
                end
            end
            CMD_READ: begin
                s = fd_issued(req.fd) ? match_slot(req.fd, 1'b0) : -1;
                if (s < 0) begin
                    r.status = ST_BAD_FD;
                end else if (fill[s] == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = ring[s*RING_DEPTH + int'(head[s])];
                    head[s]    = 8'((int'(head[s]) + 1) % RING_DEPTH);
                    fill[s]    = fill[s] - 9'd1;
                end
            end
            default: begin
                // destroy: match only, no range test
                s = match_slot(req.fd, 1'b1);
                if (s < 0) r.status = ST_BAD_FD;
                else used[s] = 1'b0;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                used[s]   = 1'b0;
                rd_end[s] = '0;
                wr_end[s] = '0;
                head[s]   = '0;
                tail[s]   = '0;
                fill[s]   = '0;
            end
            next_fd = 16'(DESC_BASE);
            pending_results.delete();
        end else begin
            if (i_valid !== 1'b0) begin
                if (pending_results.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unexpected result, status=%0d", $realtime, i_res.status);
                end else begin
                    want = pending_results.pop_front();
                    if (i_valid !== 1'b1 ||
                        i_res.status       !== want.status       ||
                        i_res.slot         !== want.slot         ||
                        i_res.read_end_fd  !== want.read_end_fd  ||
                        i_res.write_end_fd !== want.write_end_fd ||
                        i_res.data_out     !== want.data_out     ||
                        i_res.transfer_end !== want.transfer_end) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display({"%0t: mismatch exp st=%0d slot=%0d rd=%h wr=%h d=%h e=%b",
                                      " got st=%0d slot=%0d rd=%h wr=%h d=%h e=%b"},
                                     $realtime, want.status, want.slot, want.read_end_fd,
                                     want.write_end_fd, want.data_out, want.transfer_end,
                                     i_res.status, i_res.slot, i_res.read_end_fd,
                                     i_res.write_end_fd, i_res.data_out, i_res.transfer_end);
                    end
                end
            end
            if (i_start && !i_busy) pending_results.push_back(next_pipe_result(i_req));
        end
        o_fail_count <= fails;
        o_pending    <= pending_results.size();
    end

endmodule

// ===== tb/sv/tb_pipe_table_ring_fifo_core.sv =====
// Stimulus and verdict for the pipe table ring FIFO core.
`timescale 1ns / 100ps

module tb_pipe_table_ring_fifo_core;
    import ptrf_pkg::*;

    localparam int          SLOTS        = 8;
    localparam int          RING_DEPTH   = 256;
    localparam longint      RUN_LIMIT_NS = 64'd4_000_000;
    // first pipe created, kept alive through the ring fill pass
    localparam logic [15:0] KEEP_RFD     = 16'd2;
    localparam logic [15:0] KEEP_WFD     = 16'd3;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_valid;
    t_req i_req;
    t_res o_res;
    int   fail_count;
    int   pending;

    pipe_table_ring_fifo_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    pipe_table_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_valid      (o_valid),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Loose view of which pipes are open, built from the results. It only
    // steers the stimulus towards live descriptors; it lags the block by the
    // result latency, so stale picks simply become bad-descriptor requests.
    t_req        sent_q[$];
    int          req_count = 0;
    int          res_count;
    logic        live    [SLOTS];
    logic [15:0] live_rd [SLOTS];
    logic [15:0] live_wr [SLOTS];
    logic [15:0] last_wr;

    always @(posedge i_clk) begin
        t_req q;
        int   hit;
        if (!i_rst_n) begin
            res_count <= 0;
            last_wr   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                live[i]    <= 1'b0;
                live_rd[i] <= '0;
                live_wr[i] <= '0;
            end
        end else if (o_valid === 1'b1 && sent_q.size() != 0) begin
            q         = sent_q.pop_front();
            res_count <= res_count + 1;
            if (o_res.status == ST_OK && q.command == CMD_CREATE) begin
                live[o_res.slot]    <= 1'b1;
                live_rd[o_res.slot] <= o_res.read_end_fd;
                live_wr[o_res.slot] <= o_res.write_end_fd;
                last_wr             <= o_res.write_end_fd;
            end else if (o_res.status == ST_OK && q.command == CMD_DESTROY) begin
                hit = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (live[i] && live_wr[i] == q.fd) hit = i;
                if (hit >= 0) live[hit] <= 1'b0;
            end
        end
    end

    function automatic t_req mk(t_cmd cmd, logic [15:0] fd, logic [7:0] data, logic eot);
        t_req r;
        r.command         = cmd;
        r.fd              = fd;
        r.data_in         = data;
        r.end_of_transfer = eot;
        return r;
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic int pick_live();
        int s;
        repeat (4) begin
            s = $urandom_range(SLOTS - 1);
            if (live[s]) return s;
        end
        for (int i = 0; i < SLOTS; i++) if (live[i]) return i;
        return -1;
    endfunction

    // descriptors off the live set: builtins, top of range, random, and
    // values either side of the next one to be issued
    function automatic logic [15:0] noise_fd();
        case ($urandom_range(4))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(65535));
            default: return last_wr + 16'($urandom_range(3));
        endcase
    endfunction

    // Present one request, holding start until the edge that takes it.
    // The sender first idles for a random number of cycles.
    task automatic send_item(input t_req r, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent_q.push_back(r);
        req_count++;
    endtask

    // wait for every request sent so far to have its result back
    task automatic settle();
        start <= 1'b0;
        while (res_count != req_count) @(posedge i_clk);
    endtask

    // Mostly requests to live pipes, some to the wrong end, some noise;
    // now and then a short run of writes or reads on one pipe.
    task automatic run_random(input int n_items, input int idle_pct, input bit protect);
        int          done;
        int          s;
        int          len;
        int          roll;
        t_cmd        cmd;
        logic [15:0] fd;
        done = 0;
        while (done < n_items) begin
            s    = pick_live();
            roll = $urandom_range(99);
            if (roll < 8 && s >= 0) begin
                len = $urandom_range(2, 12);
                cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
                fd  = (cmd == CMD_WRITE) ? live_wr[s] : live_rd[s];
                repeat (len) send_item(mk(cmd, fd, rnd_byte(), 1'($urandom_range(1))), idle_pct);
                done += len;
            end else begin
                roll = $urandom_range(99);
                cmd  = roll < 14 ? CMD_CREATE : roll < 50 ? CMD_WRITE :
                       roll < 86 ? CMD_READ : CMD_DESTROY;
                roll = $urandom_range(99);
                if (s >= 0 && roll < 80)
                    fd = (cmd == CMD_READ) ? live_rd[s] : live_wr[s];
                else if (s >= 0 && roll < 88)
                    fd = (cmd == CMD_READ) ? live_wr[s] : live_rd[s];
                else
                    fd = noise_fd();
                // the long-lived pipe must survive until the ring fill pass
                if (protect && cmd == CMD_DESTROY && fd == KEEP_WFD) cmd = CMD_WRITE;
                send_item(mk(cmd, fd, rnd_byte(), 1'($urandom_range(1))), idle_pct);
                done++;
            end
        end
    endtask

    initial begin
        start   <= 1'b0;
        i_req   <= '0;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // nothing issued yet: range and match rejects
        send_item(mk(CMD_WRITE,   KEEP_WFD, 8'h11, 1'b0), 0);
        send_item(mk(CMD_READ,    KEEP_RFD, 8'h00, 1'b1), 0);
        send_item(mk(CMD_DESTROY, KEEP_WFD, 8'h00, 1'b0), 0);
        // first pipe, data extremes, then read past the end
        send_item(mk(CMD_CREATE,  16'd0,    8'h00, 1'b1), 0);
        send_item(mk(CMD_WRITE,   KEEP_WFD, 8'hFF, 1'b1), 0);
        send_item(mk(CMD_WRITE,   KEEP_WFD, 8'h00, 1'b0), 0);
        send_item(mk(CMD_WRITE,   KEEP_WFD, 8'hA5, 1'b1), 0);
        repeat (4) send_item(mk(CMD_READ, KEEP_RFD, 8'h00, 1'b0), 0);
        // wrong end, builtin descriptors, beyond the counter
        send_item(mk(CMD_READ,    KEEP_WFD, 8'h00, 1'b1), 0);
        send_item(mk(CMD_WRITE,   KEEP_RFD, 8'h5A, 1'b0), 0);
        send_item(mk(CMD_WRITE,   16'd0,    8'h01, 1'b0), 0);
        send_item(mk(CMD_READ,    16'd1,    8'h00, 1'b1), 0);
        send_item(mk(CMD_WRITE,   16'hFFFF, 8'h80, 1'b0), 0);
        send_item(mk(CMD_DESTROY, 16'hFFFF, 8'h00, 1'b1), 0);
        send_item(mk(CMD_DESTROY, KEEP_RFD, 8'h00, 1'b0), 0);
        // fill the table, one create too many, free slot 1 and refill it
        repeat (8) send_item(mk(CMD_CREATE, 16'hFFFF, 8'hFF, 1'b0), 0);
        send_item(mk(CMD_DESTROY, 16'd5,    8'h00, 1'b0), 0);
        send_item(mk(CMD_CREATE,  16'd0,    8'h00, 1'b1), 0);
        settle();

        // ---- random part, three idling regimes ----
        run_random(150, 34, 1'b1);
        // one pass through a full ring and back to empty, pointers wrapping
        repeat (RING_DEPTH + 4) send_item(mk(CMD_WRITE, KEEP_WFD, rnd_byte(), 1'b0), 54);
        repeat (RING_DEPTH + 4) send_item(mk(CMD_READ,  KEEP_RFD, 8'h00, 1'b1), 54);
        run_random(150, 54, 1'b0);
        run_random(150, 0, 1'b0);

        // ---- end of run ----
        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
